@@ rtl/core/serial_line_assembler_idle_timeout_assert.svh @@
// assertion macros for the serial line assembler
`ifndef SERIAL_LINE_ASSEMBLER_IDLE_TIMEOUT_ASSERT_SVH
`define SERIAL_LINE_ASSEMBLER_IDLE_TIMEOUT_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define SLA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, clocked on clock, off during reset
`define SLA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/sla_pkg.sv @@
// shared types and constants of the serial line assembler
package sla_pkg;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 16;

   localparam logic [BYTE_W-1:0]  CHAR_CR       = 8'h0D;
   localparam logic [BYTE_W-1:0]  CHAR_LF       = 8'h0A;
   localparam logic [COUNT_W-1:0] TIMEOUT_RESET = 16'd300;
   localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // control from the front end to the line emitter
   typedef struct packed {
      logic wr_en;
      logic start;
   } sla_emit_ctl_type;

   // status from the line emitter
   typedef struct packed {
      logic busy;
   } sla_emit_sts_type;

endpackage

@@ rtl/core/serial_line_assembler_idle_timeout.sv @@
// serial line assembler with idle timeout, top level
//
// Each input word is a received byte or one time tick. A byte or a tick that emits
// nothing is taken back to back. A CR or LF with bytes pending, or a tick that brings
// the idle count to or past the timeout with bytes pending, sends the line of at most
// LINE_DEPTH - 1 bytes out one byte a cycle while the result side does not stall, from
// the single read port of the line store; input stalls until it is read out. The last
// result word stays in the output register and does not hold up the input. The timeout
// register may be written only while idle.
`include "serial_line_assembler_idle_timeout_assert.svh"

module serial_line_assembler_idle_timeout #(
   parameter int LINE_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [sla_pkg::BYTE_W-1:0]    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sla_pkg::BYTE_W-1:0]    rsp_line_byte,
   output logic                          rsp_last_of_line,
   input  logic                          csr_wr_en,
   input  logic [sla_pkg::COUNT_W-1:0]   csr_wr_data
);

   localparam int            AW      = $clog2(LINE_DEPTH);
   localparam logic [AW-1:0] LEN_MAX = AW'(LINE_DEPTH - 1);

   logic [AW-1:0]               len_ff, len_in;
   logic [sla_pkg::COUNT_W-1:0] idle_ff, idle_in;
   logic [sla_pkg::COUNT_W-1:0] timeout_ff;
   logic [sla_pkg::COUNT_W-1:0] idle_inc;

   sla_pkg::sla_emit_ctl_type ctl;
   sla_pkg::sla_emit_sts_type sts;

   logic accept;
   logic is_delim;

   assign req_stall = sts.busy;
   assign accept    = req_valid && !req_stall;
   assign is_delim  = (req_rx_byte == sla_pkg::CHAR_CR) || (req_rx_byte == sla_pkg::CHAR_LF);
   assign idle_inc  = (idle_ff == sla_pkg::COUNT_MAX) ? idle_ff : idle_ff + 16'd1;

   // item decode: append, emit or count
   always_comb begin
      len_in    = len_ff;
      idle_in   = idle_ff;
      ctl.wr_en = 1'b0;
      ctl.start = 1'b0;
      if (accept) begin
         if (req_func == sla_pkg::FUNC_BYTE) begin
            idle_in = '0;
            if (is_delim) begin
               if (len_ff != '0) begin
                  ctl.start = 1'b1;
                  len_in    = '0;
               end
            end else if (len_ff != LEN_MAX) begin
               ctl.wr_en = 1'b1;
               len_in    = len_ff + AW'(1);
            end
         end else begin
            idle_in = idle_inc;
            if ((len_ff != '0) && (idle_inc >= timeout_ff)) begin
               ctl.start = 1'b1;
               len_in    = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         idle_ff    <= '0;
         timeout_ff <= sla_pkg::TIMEOUT_RESET;
      end else begin
         len_ff  <= len_in;
         idle_ff <= idle_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   // line store and emitter
   sla_emit #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_emit (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .sts              (sts),
      .wr_addr          (len_ff),
      .wr_data          (req_rx_byte),
      .start_len        (len_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_byte    (rsp_line_byte),
      .rsp_last_of_line (rsp_last_of_line)
   );

   // checks
   `SLA_ASSERT_NOW(a_emit_nonempty, ctl.start, len_ff != '0)
   `SLA_ASSERT_NOW(a_len_bound, 1'b1, len_ff <= LEN_MAX)
   `SLA_ASSERT_NEXT(a_stall_after_start, ctl.start, req_stall && (len_ff == '0))
   `SLA_ASSERT_NOW(a_no_write_while_busy, ctl.wr_en, !sts.busy)

endmodule

@@ rtl/core/sla_emit.sv @@
// line store memory and the emitter that walks it onto the result channel
module sla_emit #(
   parameter int LINE_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sla_pkg::sla_emit_ctl_type     ctl,
   output sla_pkg::sla_emit_sts_type     sts,
   input  logic [$clog2(LINE_DEPTH)-1:0] wr_addr,
   input  logic [sla_pkg::BYTE_W-1:0]    wr_data,
   input  logic [$clog2(LINE_DEPTH)-1:0] start_len,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sla_pkg::BYTE_W-1:0]    rsp_line_byte,
   output logic                          rsp_last_of_line
);

   localparam int AW = $clog2(LINE_DEPTH);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic [sla_pkg::BYTE_W-1:0] line_mem [LINE_DEPTH];

   logic                       state_ff, state_in;
   logic [AW-1:0]              idx_ff, idx_in;
   logic [AW-1:0]              len_ff, len_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic                       rd_last_ff;
   logic [sla_pkg::BYTE_W-1:0] ram_q_ff;
   logic                       out_vld_ff, out_vld_in;
   logic [sla_pkg::BYTE_W-1:0] out_byte_ff;
   logic                       out_last_ff;

   logic issue;
   logic move;

   // read data moves to the output register when that slot frees
   assign move  = rd_vld_ff && (!out_vld_ff || !rsp_stall);
   // one memory read per cycle while bytes remain and the read slot drains
   assign issue = (state_ff == ST_RUN) && (idx_ff != len_ff) && (!rd_vld_ff || move);

   // walk sequencer
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      len_in   = len_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               state_in = ST_RUN;
               idx_in   = '0;
               len_in   = start_len;
            end
         end
         ST_RUN: begin
            if (issue) begin
               idx_in = idx_ff + AW'(1);
            end else if (idx_ff == len_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // read slot and output register occupancy
   always_comb begin
      rd_vld_in = rd_vld_ff;
      if (issue) begin
         rd_vld_in = 1'b1;
      end else if (move) begin
         rd_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (move) begin
         out_vld_in = 1'b1;
      end else if (out_vld_ff && !rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      len_ff <= len_in;
   end

   // line store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         ram_q_ff   <= line_mem[idx_ff];
         rd_last_ff <= (idx_ff + AW'(1)) == len_ff;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (move) begin
         out_byte_ff <= ram_q_ff;
         out_last_ff <= rd_last_ff;
      end
   end

   assign sts.busy         = (state_ff == ST_RUN) || rd_vld_ff;
   assign rsp_valid        = out_vld_ff;
   assign rsp_line_byte    = out_byte_ff;
   assign rsp_last_of_line = out_last_ff;

endmodule
